// ----- rtl/core/ecef_to_geodetic_assert.svh -----
// ----------------------------------------------------------------------------
// ecef_to_geodetic_assert.svh
// assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef ECEF_TO_GEODETIC_ASSERT_SVH
`define ECEF_TO_GEODETIC_ASSERT_SVH

// same-cycle implication, sampled on aclk, quiet during reset
`define ECEFG_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("ecef_to_geodetic check failed");

// next-cycle implication, sampled on aclk, quiet during reset
`define ECEFG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("ecef_to_geodetic check failed");

`endif

// ----- rtl/core/ecefg_pkg.sv -----
// ----------------------------------------------------------------------------
// ecefg_pkg
// shared types, constants and helpers of the ecef to geodetic pipeline
// ----------------------------------------------------------------------------
package ecefg_pkg;

    localparam int CORDIC_STAGES = 32;
    localparam int LANES         = 4;
    localparam int SQ_STEPS      = 32;
    localparam int MUL_LAT       = 3;

    localparam logic signed [63:0] HALF_TURN    = 64'sd2147483648;
    localparam logic signed [63:0] QUARTER_TURN = 64'sd1073741824;
    localparam logic signed [63:0] ONE_Q30      = 64'sd1073741824;
    localparam logic signed [63:0] KINV_Q30     = 64'sd652032874;
    localparam logic signed [63:0] KINV_Q32     = 64'sd2608131496;
    localparam logic signed [63:0] OMF_Q32      = 64'sd4280567084;
    localparam logic signed [63:0] E2_Q32       = 64'sd28752143;
    localparam logic signed [63:0] A_CM         = 64'sd637813700;
    localparam logic signed [63:0] B_Q16   = 64'sd635675231 * 64'sd65536 + 64'sd27821;
    localparam logic signed [63:0] EA_Q16  = 64'sd4269767 * 64'sd65536 + 64'sd17742;
    localparam logic signed [63:0] EPB_Q16 = 64'sd4284131 * 64'sd65536 + 64'sd9918;
    localparam logic signed [63:0] DEG_SCALE = 64'sd1800000000;
    localparam logic [63:0]        MAG_MAX   = 64'h3FFF_FFFF_FFFF_FFFF;

    localparam logic signed [63:0] LAT_MAX = 64'sd900000000;
    localparam logic signed [63:0] LON_MAX = 64'sd1800000000;
    localparam logic signed [63:0] H_MIN   = -64'sd700000000;
    localparam logic signed [63:0] H_MAX   = 64'sd1100000000;

    localparam logic [5:0] SH_14 = 6'd14;
    localparam logic [5:0] SH_30 = 6'd30;
    localparam logic [5:0] SH_31 = 6'd31;
    localparam logic [5:0] SH_32 = 6'd32;

    localparam logic [31:0] ATAN_TAB [0:47] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326,
        32'd163, 32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1,
        32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0,
        32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0
    };

    typedef logic signed [63:0] lane_t [LANES];
    typedef logic [5:0]         shv_t  [LANES];

    // per-item values that ride along the pipeline
    typedef struct packed {
        logic               axis;
        logic signed [30:0] z;
        logic signed [63:0] pxy;
        logic signed [63:0] lon;
        logic signed [63:0] lat;
        logic signed [63:0] ct;
        logic signed [63:0] st;
        logic signed [63:0] hp;
        logic signed [63:0] hz;
    } side_t;

    function automatic logic signed [63:0] zq_of(input logic signed [30:0] z);
        return 64'(z) <<< 16;
    endfunction

    // round(v / 2^16), half away from zero
    function automatic logic signed [63:0] rnd16(input logic signed [63:0] v);
        logic [63:0] m;
        m = v[63] ? 64'(-v) : 64'(v);
        m = (m + 64'd32768) >> 16;
        return v[63] ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic signed [63:0] clamp64(input logic signed [63:0] v,
                                                   input logic signed [63:0] lo,
                                                   input logic signed [63:0] hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

endpackage

// ----- rtl/core/ecefg_mul4.sv -----
// ----------------------------------------------------------------------------
// ecefg_mul4
// four-lane rounded fixed-point multiplier, 32x32 partial products, 3 stages
// ----------------------------------------------------------------------------
module ecefg_mul4 (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_v,
    input  ecefg_pkg::side_t     in_side,
    input  ecefg_pkg::lane_t     a,
    input  ecefg_pkg::lane_t     b,
    input  ecefg_pkg::shv_t      sh,
    output logic                 out_v,
    output ecefg_pkg::side_t     out_side,
    output ecefg_pkg::lane_t     res
);

    logic             s1_v_reg, s2_v_reg, s3_v_reg;
    ecefg_pkg::side_t s1_side_reg, s2_side_reg, s3_side_reg;
    logic [63:0]      ua_reg [ecefg_pkg::LANES];
    logic [63:0]      ub_reg [ecefg_pkg::LANES];
    logic             s1_neg_reg [ecefg_pkg::LANES];
    logic             s2_neg_reg [ecefg_pkg::LANES];
    ecefg_pkg::shv_t  s1_sh_reg, s2_sh_reg;
    logic [63:0]      p00_reg [ecefg_pkg::LANES];
    logic [63:0]      p01_reg [ecefg_pkg::LANES];
    logic [63:0]      p10_reg [ecefg_pkg::LANES];
    logic [63:0]      p11_reg [ecefg_pkg::LANES];
    ecefg_pkg::lane_t res_reg, res_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
        end else if (en) begin
            s1_v_reg <= in_v;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_side_reg <= in_side;
            s2_side_reg <= s1_side_reg;
            s3_side_reg <= s2_side_reg;
            s1_sh_reg   <= sh;
            s2_sh_reg   <= s1_sh_reg;
            res_reg     <= res_next;
            for (int k = 0; k < ecefg_pkg::LANES; k++) begin
                ua_reg[k]     <= a[k][63] ? 64'(-a[k]) : 64'(a[k]);
                ub_reg[k]     <= b[k][63] ? 64'(-b[k]) : 64'(b[k]);
                s1_neg_reg[k] <= a[k][63] != b[k][63];
                s2_neg_reg[k] <= s1_neg_reg[k];
                p00_reg[k]    <= ua_reg[k][31:0]  * ub_reg[k][31:0];
                p01_reg[k]    <= ua_reg[k][31:0]  * ub_reg[k][63:32];
                p10_reg[k]    <= ua_reg[k][63:32] * ub_reg[k][31:0];
                p11_reg[k]    <= ua_reg[k][63:32] * ub_reg[k][63:32];
            end
        end
    end

    // sum partial products, round half away, shift, saturate, sign
    always_comb begin
        logic [127:0] prod;
        logic [127:0] rsum;
        logic [63:0]  m;
        for (int k = 0; k < ecefg_pkg::LANES; k++) begin
            prod = 128'(p00_reg[k]) + (128'(p01_reg[k]) << 32)
                 + (128'(p10_reg[k]) << 32) + (128'(p11_reg[k]) << 64);
            rsum = (prod + (128'd1 << (s2_sh_reg[k] - 6'd1))) >> s2_sh_reg[k];
            m    = rsum[63:0];
            if (m > ecefg_pkg::MAG_MAX) begin
                m = ecefg_pkg::MAG_MAX;
            end
            res_next[k] = s2_neg_reg[k] ? -$signed(m) : $signed(m);
        end
    end

    assign out_v    = s3_v_reg;
    assign out_side = s3_side_reg;
    assign res      = res_reg;

endmodule

// ----- rtl/core/ecefg_cordic.sv -----
// ----------------------------------------------------------------------------
// ecefg_cordic
// unrolled cordic, one register per iteration, vectoring or rotation mode
// ----------------------------------------------------------------------------
module ecefg_cordic (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 rotate,
    input  logic                 in_v,
    input  ecefg_pkg::side_t     in_side,
    input  logic signed [63:0]   in_x,
    input  logic signed [63:0]   in_y,
    input  logic signed [63:0]   in_t,
    output logic                 out_v,
    output ecefg_pkg::side_t     out_side,
    output logic signed [63:0]   out_x,
    output logic signed [63:0]   out_y,
    output logic signed [63:0]   out_t
);

    localparam int N = ecefg_pkg::CORDIC_STAGES;

    logic               v_reg    [0:N];
    ecefg_pkg::side_t   side_reg [0:N];
    logic signed [63:0] x_reg    [0:N];
    logic signed [63:0] y_reg    [0:N];
    logic signed [63:0] t_reg    [0:N];
    logic               flip_reg [0:N];

    logic signed [63:0] x0_next, y0_next, t0_next;
    logic               flip0_next;

    // quadrant fold ahead of the iterations
    always_comb begin
        x0_next    = in_x;
        y0_next    = in_y;
        t0_next    = '0;
        flip0_next = 1'b0;
        if (rotate) begin
            x0_next = ecefg_pkg::KINV_Q30;
            y0_next = '0;
            t0_next = in_t;
            if (in_t > ecefg_pkg::QUARTER_TURN) begin
                t0_next    = in_t - ecefg_pkg::HALF_TURN;
                flip0_next = 1'b1;
            end else if (in_t < -ecefg_pkg::QUARTER_TURN) begin
                t0_next    = in_t + ecefg_pkg::HALF_TURN;
                flip0_next = 1'b1;
            end
        end else if (in_x[63]) begin
            if (!in_y[63]) begin
                x0_next = in_y;
                y0_next = -in_x;
                t0_next = ecefg_pkg::QUARTER_TURN;
            end else begin
                x0_next = -in_y;
                y0_next = in_x;
                t0_next = -ecefg_pkg::QUARTER_TURN;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg[0] <= 1'b0;
        end else if (en) begin
            v_reg[0] <= in_v;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= in_side;
            x_reg[0]    <= x0_next;
            y_reg[0]    <= y0_next;
            t_reg[0]    <= t0_next;
            flip_reg[0] <= flip0_next;
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_iter
        logic signed [63:0] x_next, y_next, t_next, dx, dy, ang;
        logic               up;

        always_comb begin
            dx  = y_reg[i] >>> i;
            dy  = x_reg[i] >>> i;
            ang = 64'(ecefg_pkg::ATAN_TAB[i]);
            up  = rotate ? !t_reg[i][63] : !y_reg[i][63];
            if (rotate == up) begin
                // rotation with t >= 0, vectoring with y < 0
                x_next = x_reg[i] - dx;
                y_next = y_reg[i] + dy;
                t_next = t_reg[i] - ang;
            end else begin
                // vectoring with y >= 0 mirrors rotation with t < 0
                x_next = x_reg[i] + dx;
                y_next = y_reg[i] - dy;
                t_next = t_reg[i] + ang;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[i+1] <= 1'b0;
            end else if (en) begin
                v_reg[i+1] <= v_reg[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                side_reg[i+1] <= side_reg[i];
                x_reg[i+1]    <= x_next;
                y_reg[i+1]    <= y_next;
                t_reg[i+1]    <= t_next;
                flip_reg[i+1] <= flip_reg[i];
            end
        end
    end

    assign out_v    = v_reg[N];
    assign out_side = side_reg[N];
    assign out_x    = flip_reg[N] ? -x_reg[N] : x_reg[N];
    assign out_y    = flip_reg[N] ? -y_reg[N] : y_reg[N];
    assign out_t    = t_reg[N];

endmodule

// ----- rtl/core/ecef_to_geodetic.sv -----
// ----------------------------------------------------------------------------
// ecef_to_geodetic
// earth-fixed position to wgs84 latitude, longitude, height (bowring, one pass)
// ----------------------------------------------------------------------------
//  channel | handshake          | word
//  --------+--------------------+--------------------------------------------
//  input   | s_valid / s_ready  | s_ecef_x, s_ecef_y, s_ecef_z (cm)
//  result  | m_valid / m_ready  | m_latitude, m_longitude (1e-7 deg),
//          |                    | m_height (cm), m_on_axis
//
//  one word accepted per clock while the output register is empty or being
//  taken; the datapath runs through the five cordic pipelines and the
//  32-step square root
//  aresetn clears every valid bit; payload registers are not reset
//  the whole pipe advances together whenever the output register is
//  empty or being taken, so a stall freezes every stage in place
// ----------------------------------------------------------------------------
module ecef_to_geodetic (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [30:0] s_ecef_x,
    input  logic signed [30:0] s_ecef_y,
    input  logic signed [30:0] s_ecef_z,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [30:0] m_latitude,
    output logic signed [31:0] m_longitude,
    output logic signed [31:0] m_height,
    output logic               m_on_axis
);

    // global advance: output slot free or draining
    logic en;
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    // ---------------- input register ----------------
    logic               in_v_reg;
    ecefg_pkg::side_t   in_side_reg, in_side_next;
    logic signed [30:0] in_x_reg, in_y_reg;

    always_comb begin
        in_side_next      = '0;
        in_side_next.z    = s_ecef_z;
        in_side_next.axis = (s_ecef_x == '0) && (s_ecef_y == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_v_reg <= 1'b0;
        end else if (en) begin
            in_v_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            in_x_reg    <= s_ecef_x;
            in_y_reg    <= s_ecef_y;
            in_side_reg <= in_side_next;
        end
    end

    // ---------------- longitude angle and xy magnitude ----------------
    logic               v1_v;
    ecefg_pkg::side_t   v1_side;
    logic signed [63:0] v1_x, v1_y, v1_t;

    ecefg_cordic u_vec_lon (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .rotate   (1'b0),
        .in_v     (in_v_reg),
        .in_side  (in_side_reg),
        .in_x     (64'(in_x_reg) <<< 16),
        .in_y     (64'(in_y_reg) <<< 16),
        .in_t     (64'sd0),
        .out_v    (v1_v),
        .out_side (v1_side),
        .out_x    (v1_x),
        .out_y    (v1_y),
        .out_t    (v1_t)
    );

    // gain removal gives p; longitude scaled to 1e-7 deg in parallel
    ecefg_pkg::lane_t mc_a, mc_b, mc_r;
    ecefg_pkg::shv_t  mc_sh;
    logic             mc_v;
    ecefg_pkg::side_t mc_side, c_side;

    always_comb begin
        mc_a  = '{v1_x, v1_t, v1_y, 64'sd0};
        mc_b  = '{ecefg_pkg::KINV_Q32, ecefg_pkg::DEG_SCALE, 64'sd0, 64'sd0};
        mc_sh = '{ecefg_pkg::SH_32, ecefg_pkg::SH_31, ecefg_pkg::SH_32, ecefg_pkg::SH_32};
    end

    ecefg_mul4 u_mul_p (
        .aclk (aclk), .aresetn (aresetn), .en (en),
        .in_v (v1_v), .in_side (v1_side),
        .a (mc_a), .b (mc_b), .sh (mc_sh),
        .out_v (mc_v), .out_side (mc_side), .res (mc_r)
    );

    always_comb begin
        c_side     = mc_side;
        c_side.pxy = mc_r[0];
        c_side.lon = mc_r[1];
    end

    // p * (1 - f)
    ecefg_pkg::lane_t md_a, md_b, md_r;
    ecefg_pkg::shv_t  md_sh;
    logic             md_v;
    ecefg_pkg::side_t md_side;

    always_comb begin
        md_a  = '{c_side.pxy, 64'sd0, 64'sd0, 64'sd0};
        md_b  = '{ecefg_pkg::OMF_Q32, 64'sd0, 64'sd0, 64'sd0};
        md_sh = '{ecefg_pkg::SH_32, ecefg_pkg::SH_32, ecefg_pkg::SH_32, ecefg_pkg::SH_32};
    end

    ecefg_mul4 u_mul_omf (
        .aclk (aclk), .aresetn (aresetn), .en (en),
        .in_v (mc_v), .in_side (c_side),
        .a (md_a), .b (md_b), .sh (md_sh),
        .out_v (md_v), .out_side (md_side), .res (md_r)
    );

    // ---------------- parametric angle theta ----------------
    logic               v2_v;
    ecefg_pkg::side_t   v2_side;
    logic signed [63:0] v2_x, v2_y, v2_t;

    ecefg_cordic u_vec_theta (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .rotate   (1'b0),
        .in_v     (md_v),
        .in_side  (md_side),
        .in_x     (md_r[0]),
        .in_y     (ecefg_pkg::zq_of(md_side.z)),
        .in_t     (64'sd0),
        .out_v    (v2_v),
        .out_side (v2_side),
        .out_x    (v2_x),
        .out_y    (v2_y),
        .out_t    (v2_t)
    );

    logic               r1_v;
    ecefg_pkg::side_t   r1_side, f_side;
    logic signed [63:0] r1_c, r1_s, r1_t;

    ecefg_cordic u_rot_theta (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .rotate   (1'b1),
        .in_v     (v2_v),
        .in_side  (v2_side),
        .in_x     (v2_x),
        .in_y     (v2_y),
        .in_t     (v2_t),
        .out_v    (r1_v),
        .out_side (r1_side),
        .out_x    (r1_c),
        .out_y    (r1_s),
        .out_t    (r1_t)
    );

    always_comb begin
        f_side    = r1_side;
        f_side.ct = r1_c;
        f_side.st = r1_s;
    end

    // cos^2, sin^2
    ecefg_pkg::lane_t mg_a, mg_b, mg_r;
    ecefg_pkg::shv_t  mg_sh;
    logic             mg_v;
    ecefg_pkg::side_t mg_side;

    always_comb begin
        mg_a  = '{f_side.ct, f_side.st, r1_t, 64'sd0};
        mg_b  = '{f_side.ct, f_side.st, 64'sd0, 64'sd0};
        mg_sh = '{ecefg_pkg::SH_30, ecefg_pkg::SH_30, ecefg_pkg::SH_30, ecefg_pkg::SH_30};
    end

    ecefg_mul4 u_mul_sq (
        .aclk (aclk), .aresetn (aresetn), .en (en),
        .in_v (r1_v), .in_side (f_side),
        .a (mg_a), .b (mg_b), .sh (mg_sh),
        .out_v (mg_v), .out_side (mg_side), .res (mg_r)
    );

    // cos^3, sin^3
    ecefg_pkg::lane_t mh_a, mh_b, mh_r;
    ecefg_pkg::shv_t  mh_sh;
    logic             mh_v;
    ecefg_pkg::side_t mh_side;

    always_comb begin
        mh_a  = '{mg_r[0], mg_r[1], mg_r[2], 64'sd0};
        mh_b  = '{mg_side.ct, mg_side.st, 64'sd0, 64'sd0};
        mh_sh = '{ecefg_pkg::SH_30, ecefg_pkg::SH_30, ecefg_pkg::SH_30, ecefg_pkg::SH_30};
    end

    ecefg_mul4 u_mul_cube (
        .aclk (aclk), .aresetn (aresetn), .en (en),
        .in_v (mg_v), .in_side (mg_side),
        .a (mh_a), .b (mh_b), .sh (mh_sh),
        .out_v (mh_v), .out_side (mh_side), .res (mh_r)
    );

    // e^2 a cos^3, e'^2 b sin^3
    ecefg_pkg::lane_t mi_a, mi_b, mi_r;
    ecefg_pkg::shv_t  mi_sh;
    logic             mi_v;
    ecefg_pkg::side_t mi_side;

    always_comb begin
        mi_a  = '{ecefg_pkg::EA_Q16, ecefg_pkg::EPB_Q16, mh_r[2], 64'sd0};
        mi_b  = '{mh_r[0], mh_r[1], 64'sd0, 64'sd0};
        mi_sh = '{ecefg_pkg::SH_30, ecefg_pkg::SH_30, ecefg_pkg::SH_30, ecefg_pkg::SH_30};
    end

    ecefg_mul4 u_mul_corr (
        .aclk (aclk), .aresetn (aresetn), .en (en),
        .in_v (mh_v), .in_side (mh_side),
        .a (mi_a), .b (mi_b), .sh (mi_sh),
        .out_v (mi_v), .out_side (mi_side), .res (mi_r)
    );

    // corrected numerator and denominator for the latitude atan2
    logic               j_v_reg;
    ecefg_pkg::side_t   j_side_reg;
    logic signed [63:0] j_num_reg, j_den_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            j_v_reg <= 1'b0;
        end else if (en) begin
            j_v_reg <= mi_v;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            j_side_reg <= mi_side;
            j_num_reg  <= ecefg_pkg::zq_of(mi_side.z) + mi_r[1];
            j_den_reg  <= mi_side.pxy - mi_r[0];
        end
    end

    // ---------------- latitude angle and its sine, cosine ----------------
    logic               v3_v;
    ecefg_pkg::side_t   v3_side, k_side;
    logic signed [63:0] v3_x, v3_y, v3_t;

    ecefg_cordic u_vec_lat (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .rotate   (1'b0),
        .in_v     (j_v_reg),
        .in_side  (j_side_reg),
        .in_x     (j_den_reg),
        .in_y     (j_num_reg),
        .in_t     (64'sd0),
        .out_v    (v3_v),
        .out_side (v3_side),
        .out_x    (v3_x),
        .out_y    (v3_y),
        .out_t    (v3_t)
    );

    // raw latitude angle parks in the lat slot until it is scaled
    always_comb begin
        k_side     = v3_side;
        k_side.lat = v3_t;
    end

    logic               r2_v;
    ecefg_pkg::side_t   r2_side;
    logic signed [63:0] r2_c, r2_s, r2_t;

    ecefg_cordic u_rot_lat (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .rotate   (1'b1),
        .in_v     (v3_v),
        .in_side  (k_side),
        .in_x     (v3_x),
        .in_y     (v3_y),
        .in_t     (v3_t),
        .out_v    (r2_v),
        .out_side (r2_side),
        .out_x    (r2_c),
        .out_y    (r2_s),
        .out_t    (r2_t)
    );

    // sin^2 lat, p cos lat, z sin lat, latitude in 1e-7 deg
    ecefg_pkg::lane_t mm_a, mm_b, mm_r;
    ecefg_pkg::shv_t  mm_sh;
    logic             mm_v;
    ecefg_pkg::side_t mm_side, m_side;

    always_comb begin
        mm_a  = '{r2_s, r2_side.pxy, ecefg_pkg::zq_of(r2_side.z), r2_side.lat};
        mm_b  = '{r2_s, r2_c, r2_s, ecefg_pkg::DEG_SCALE};
        mm_sh = '{ecefg_pkg::SH_30, ecefg_pkg::SH_30, ecefg_pkg::SH_30, ecefg_pkg::SH_31};
    end

    ecefg_mul4 u_mul_lat (
        .aclk (aclk), .aresetn (aresetn), .en (en),
        .in_v (r2_v), .in_side (r2_side),
        .a (mm_a), .b (mm_b), .sh (mm_sh),
        .out_v (mm_v), .out_side (mm_side), .res (mm_r)
    );

    always_comb begin
        m_side     = mm_side;
        m_side.hp  = mm_r[1];
        m_side.hz  = mm_r[2];
        m_side.lat = mm_r[3];
    end

    // e^2 sin^2 lat
    ecefg_pkg::lane_t mn_a, mn_b, mn_r;
    ecefg_pkg::shv_t  mn_sh;
    logic             mn_v;
    ecefg_pkg::side_t mn_side;

    always_comb begin
        mn_a  = '{ecefg_pkg::E2_Q32, r2_t, 64'sd0, 64'sd0};
        mn_b  = '{mm_r[0], 64'sd0, 64'sd0, 64'sd0};
        mn_sh = '{ecefg_pkg::SH_32, ecefg_pkg::SH_32, ecefg_pkg::SH_32, ecefg_pkg::SH_32};
    end

    ecefg_mul4 u_mul_e2 (
        .aclk (aclk), .aresetn (aresetn), .en (en),
        .in_v (mm_v), .in_side (m_side),
        .a (mn_a), .b (mn_b), .sh (mn_sh),
        .out_v (mn_v), .out_side (mn_side), .res (mn_r)
    );

    // ---------------- w = 1 - e^2 sin^2, then sqrt(w << 30) ----------------
    localparam int NQ = ecefg_pkg::SQ_STEPS;

    logic               sq_v_reg    [0:NQ];
    ecefg_pkg::side_t   sq_side_reg [0:NQ];
    logic [63:0]        sq_rem_reg  [0:NQ];
    logic [63:0]        sq_res_reg  [0:NQ];
    logic signed [63:0] w_next;

    always_comb begin
        w_next = ecefg_pkg::ONE_Q30 - mn_r[0];
        if (w_next[63]) begin
            w_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_v_reg[0] <= 1'b0;
        end else if (en) begin
            sq_v_reg[0] <= mn_v;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_side_reg[0] <= mn_side;
            sq_rem_reg[0]  <= 64'(w_next) << 30;
            sq_res_reg[0]  <= '0;
        end
    end

    // one result bit per step, bit weight 4^(31-k)
    for (genvar k = 0; k < NQ; k++) begin : g_sqrt
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
        logic [63:0] trial, rem_next, res_next;

        always_comb begin
            trial = sq_res_reg[k] + BIT;
            if (sq_rem_reg[k] >= trial) begin
                rem_next = sq_rem_reg[k] - trial;
                res_next = (sq_res_reg[k] >> 1) + BIT;
            end else begin
                rem_next = sq_rem_reg[k];
                res_next = sq_res_reg[k] >> 1;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sq_v_reg[k+1] <= 1'b0;
            end else if (en) begin
                sq_v_reg[k+1] <= sq_v_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                sq_side_reg[k+1] <= sq_side_reg[k];
                sq_rem_reg[k+1]  <= rem_next;
                sq_res_reg[k+1]  <= res_next;
            end
        end
    end

    // a * sqrt(w)
    ecefg_pkg::lane_t mq_a, mq_b, mq_r;
    ecefg_pkg::shv_t  mq_sh;
    logic             mq_v;
    ecefg_pkg::side_t mq_side;

    always_comb begin
        mq_a  = '{ecefg_pkg::A_CM, $signed(sq_rem_reg[NQ]), 64'sd0, 64'sd0};
        mq_b  = '{$signed(sq_res_reg[NQ]), 64'sd0, 64'sd0, 64'sd0};
        mq_sh = '{ecefg_pkg::SH_14, ecefg_pkg::SH_14, ecefg_pkg::SH_14, ecefg_pkg::SH_14};
    end

    ecefg_mul4 u_mul_rad (
        .aclk (aclk), .aresetn (aresetn), .en (en),
        .in_v (sq_v_reg[NQ]), .in_side (sq_side_reg[NQ]),
        .a (mq_a), .b (mq_b), .sh (mq_sh),
        .out_v (mq_v), .out_side (mq_side), .res (mq_r)
    );

    // ---------------- height sum ----------------
    logic               h_v_reg;
    ecefg_pkg::side_t   h_side_reg;
    logic signed [63:0] h_sum_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            h_v_reg <= 1'b0;
        end else if (en) begin
            h_v_reg <= mq_v;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            h_side_reg <= mq_side;
            h_sum_reg  <= mq_side.hp + mq_side.hz - mq_r[0];
        end
    end

    // ---------------- rounding, pole rule, saturation, output ----------------
    logic signed [63:0] lat_next, lon_next, h_next, zabs;
    logic               m_valid_reg;
    logic signed [30:0] m_latitude_reg;
    logic signed [31:0] m_longitude_reg, m_height_reg;
    logic               m_on_axis_reg;

    always_comb begin
        zabs = h_side_reg.z[30] ? -64'(h_side_reg.z) : 64'(h_side_reg.z);
        if (h_side_reg.axis) begin
            lon_next = '0;
            lat_next = h_side_reg.z[30] ? -ecefg_pkg::LAT_MAX : ecefg_pkg::LAT_MAX;
            h_next   = ecefg_pkg::rnd16((zabs <<< 16) - ecefg_pkg::B_Q16);
        end else begin
            lon_next = h_side_reg.lon;
            lat_next = h_side_reg.lat;
            h_next   = ecefg_pkg::rnd16(h_sum_reg);
        end
        lat_next = ecefg_pkg::clamp64(lat_next, -ecefg_pkg::LAT_MAX, ecefg_pkg::LAT_MAX);
        lon_next = ecefg_pkg::clamp64(lon_next, -ecefg_pkg::LON_MAX, ecefg_pkg::LON_MAX);
        h_next   = ecefg_pkg::clamp64(h_next, ecefg_pkg::H_MIN, ecefg_pkg::H_MAX);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= h_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_latitude_reg  <= lat_next[30:0];
            m_longitude_reg <= lon_next[31:0];
            m_height_reg    <= h_next[31:0];
            m_on_axis_reg   <= h_side_reg.axis;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_latitude  = m_latitude_reg;
    assign m_longitude = m_longitude_reg;
    assign m_height    = m_height_reg;
    assign m_on_axis   = m_on_axis_reg;

endmodule

// ----- rtl/core/ecefg_checker.sv -----
// ----------------------------------------------------------------------------
// ecefg_checker
// port-level checks on the ecef to geodetic block, bound to the top level
// ----------------------------------------------------------------------------
`include "ecef_to_geodetic_assert.svh"

module ecefg_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic signed [30:0] s_ecef_x,
    input  logic signed [30:0] s_ecef_y,
    input  logic signed [30:0] s_ecef_z,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic signed [30:0] m_latitude,
    input  logic signed [31:0] m_longitude,
    input  logic signed [31:0] m_height,
    input  logic               m_on_axis
);

    // a stalled result word stays put
    `ECEFG_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_latitude) && $stable(m_longitude) && $stable(m_height))

    // an empty output slot never blocks the input side
    `ECEFG_ASSERT_NOW(a_ready_when_empty, !m_valid, s_ready)

    // pole rule: zero longitude and a latitude of exactly +-90 deg
    `ECEFG_ASSERT_NOW(a_pole_word, m_valid && m_on_axis, (m_longitude == 32'sd0) && ((m_latitude == 31'sd900000000) || (m_latitude == -31'sd900000000)))

    // saturated ranges on every delivered word
    `ECEFG_ASSERT_NOW(a_out_range, m_valid, (m_latitude <= 31'sd900000000) && (m_latitude >= -31'sd900000000) && (m_longitude <= 32'sd1800000000) && (m_longitude >= -32'sd1800000000) && (m_height >= -32'sd700000000) && (m_height <= 32'sd1100000000))

endmodule

bind ecef_to_geodetic ecefg_checker u_ecefg_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .s_ecef_x    (s_ecef_x),
    .s_ecef_y    (s_ecef_y),
    .s_ecef_z    (s_ecef_z),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_latitude  (m_latitude),
    .m_longitude (m_longitude),
    .m_height    (m_height),
    .m_on_axis   (m_on_axis)
);

// ----- tb/ecef_to_geodetic_tb.sv -----
// ----------------------------------------------------------------------------
// ecef_to_geodetic_tb
// checks the ecef to geodetic pipeline word by word against a bit-exact
// fixed-point model (cordic angles, q16 lengths, rounded products), with
// directed pole / half-turn / extreme positions, then random positions
// under random input gaps and output stalls
// ----------------------------------------------------------------------------
module ecef_to_geodetic_tb;

    timeunit 1ns;
    timeprecision 1ps;

    // one earth-fixed position as sent on the input channel
    typedef struct {
        logic signed [30:0] x;
        logic signed [30:0] y;
        logic signed [30:0] z;
    } ecef_pos_t;

    // one geodetic fix as expected on the result channel
    typedef struct {
        logic signed [30:0] lat;
        logic signed [31:0] lon;
        logic signed [31:0] hgt;
        logic               axis;
    } geo_fix_t;

    localparam int PIPE_LAT    = 226;
    localparam int CYCLE_LIMIT = 200000;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic signed [30:0] s_ecef_x = '0;
    logic signed [30:0] s_ecef_y = '0;
    logic signed [30:0] s_ecef_z = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [30:0] m_latitude;
    logic signed [31:0] m_longitude;
    logic signed [31:0] m_height;
    logic               m_on_axis;

    ecef_pos_t pending_positions[$];
    geo_fix_t  expected_fixes[$];
    int        mismatch_count = 0;
    int        cycle_count = 0;
    bit        calm = 1'b0;     // no gaps and no stalls while set

    ecef_to_geodetic DUT (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_ecef_x   (s_ecef_x),
        .s_ecef_y   (s_ecef_y),
        .s_ecef_z   (s_ecef_z),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_latitude (m_latitude),
        .m_longitude(m_longitude),
        .m_height   (m_height),
        .m_on_axis  (m_on_axis)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------
    // fixed-point arithmetic helpers
    // ------------------------------------------------------------------

    function automatic logic [63:0] magnitude(input longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    // re-apply the sign, magnitude capped at 2^62 - 1
    function automatic longint signed_capped(input logic [63:0] m, input bit neg);
        if (m > ecefg_pkg::MAG_MAX) m = ecefg_pkg::MAG_MAX;
        return neg ? -longint'(m) : longint'(m);
    endfunction

    // round(v / 2^s), half away from zero
    function automatic longint round_shift(input longint v, input int s);
        logic [63:0] m;
        m = magnitude(v);
        m = (m >> 1) + ((m & 64'd1) + (64'd1 << (s - 1))) / 2;
        m = m >> (s - 1);
        return signed_capped(m, v < 0);
    endfunction

    // round(a * b / 2^s) with the full 128-bit product
    function automatic longint scaled_product(input longint a, input longint b, input int s);
        logic [127:0] p;
        p = {64'd0, magnitude(a)} * {64'd0, magnitude(b)};
        p = p + (128'd1 << (s - 1));
        p = p >> s;
        return signed_capped(p[63:0], (a < 0) != (b < 0));
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bt;
        res = 64'd0;
        bt = 64'd1 << 62;
        while (bt > v) bt = bt >> 2;
        while (bt != 0) begin
            if (v >= res + bt) begin
                v = v - (res + bt);
                res = (res >> 1) + bt;
            end else begin
                res = res >> 1;
            end
            bt = bt >> 2;
        end
        return res;
    endfunction

    function automatic longint atan_step(input int i);
        return longint'({32'd0, ecefg_pkg::ATAN_TAB[i]});
    endfunction

    // vectoring: angle of (x, y) and gain-scaled magnitude
    function automatic void vector_angle(input longint x, input longint y,
                                         output longint mag, output longint ang);
        longint z, t, dx, dy;
        z = 0;
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y; y = -t; z = ecefg_pkg::QUARTER_TURN;
            end else begin
                x = -y; y = t; z = -ecefg_pkg::QUARTER_TURN;
            end
        end
        for (int i = 0; i < ecefg_pkg::CORDIC_STAGES && i < 48; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x += dx; y -= dy; z += atan_step(i);
            end else begin
                x -= dx; y += dy; z -= atan_step(i);
            end
        end
        mag = x;
        ang = z;
    endfunction

    // rotation: q30 cosine and sine of an angle in half-turn units
    function automatic void cos_sin(input longint t, output longint c, output longint s);
        longint x, y, dx, dy;
        bit     flip;
        x = ecefg_pkg::KINV_Q30;
        y = 0;
        flip = 1'b0;
        if (t > ecefg_pkg::QUARTER_TURN) begin
            t -= ecefg_pkg::HALF_TURN; flip = 1'b1;
        end else if (t < -ecefg_pkg::QUARTER_TURN) begin
            t += ecefg_pkg::HALF_TURN; flip = 1'b1;
        end
        for (int i = 0; i < ecefg_pkg::CORDIC_STAGES && i < 48; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (t >= 0) begin
                x -= dx; y += dy; t -= atan_step(i);
            end else begin
                x += dx; y -= dy; t += atan_step(i);
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    // bowring one-pass conversion of one position
    function automatic geo_fix_t predict_geodetic(input ecef_pos_t p);
        geo_fix_t f;
        longint x, y, z, zq, lat, lon, hgt;
        longint m, lonang, th, ct, st, latang, cl, sl, pxy, num, den, s2, w, asq;
        x = p.x;
        y = p.y;
        z = p.z;
        zq = z * 65536;
        f.axis = 1'b0;
        if (x == 0 && y == 0) begin
            // pole rule
            f.axis = 1'b1;
            lon = 0;
            lat = z >= 0 ? 900000000 : -900000000;
            hgt = round_shift((z < 0 ? -zq : zq) - ecefg_pkg::B_Q16, 16);
        end else begin
            vector_angle(x * 65536, y * 65536, m, lonang);
            pxy = scaled_product(m, ecefg_pkg::KINV_Q32, 32);
            vector_angle(scaled_product(pxy, ecefg_pkg::OMF_Q32, 32), zq, m, th);
            cos_sin(th, ct, st);
            num = zq + scaled_product(ecefg_pkg::EPB_Q16,
                  scaled_product(scaled_product(st, st, 30), st, 30), 30);
            den = pxy - scaled_product(ecefg_pkg::EA_Q16,
                  scaled_product(scaled_product(ct, ct, 30), ct, 30), 30);
            vector_angle(den, num, m, latang);
            cos_sin(latang, cl, sl);
            s2 = scaled_product(sl, sl, 30);
            w = ecefg_pkg::ONE_Q30 - scaled_product(ecefg_pkg::E2_Q32, s2, 32);
            if (w < 0) w = 0;
            asq = scaled_product(ecefg_pkg::A_CM, longint'(int_sqrt(64'(w) << 30)), 14);
            hgt = scaled_product(pxy, cl, 30) + scaled_product(zq, sl, 30) - asq;
            hgt = round_shift(hgt, 16);
            lon = scaled_product(lonang, ecefg_pkg::DEG_SCALE, 31);
            lat = scaled_product(latang, ecefg_pkg::DEG_SCALE, 31);
        end
        // saturate to the output ranges
        if (lat < -ecefg_pkg::LAT_MAX) lat = -ecefg_pkg::LAT_MAX;
        if (lat > ecefg_pkg::LAT_MAX) lat = ecefg_pkg::LAT_MAX;
        if (lon < -ecefg_pkg::LON_MAX) lon = -ecefg_pkg::LON_MAX;
        if (lon > ecefg_pkg::LON_MAX) lon = ecefg_pkg::LON_MAX;
        if (hgt < ecefg_pkg::H_MIN) hgt = ecefg_pkg::H_MIN;
        if (hgt > ecefg_pkg::H_MAX) hgt = ecefg_pkg::H_MAX;
        f.lat = lat[30:0];
        f.lon = lon[31:0];
        f.hgt = hgt[31:0];
        return f;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    function automatic logic signed [30:0] span_coord(input int unsigned limit);
        return 31'($signed($urandom_range(0, 2 * limit)) - $signed(limit));
    endfunction

    task automatic queue_position(input logic signed [30:0] x,
                                  input logic signed [30:0] y,
                                  input logic signed [30:0] z);
        ecef_pos_t p;
        p.x = x;
        p.y = y;
        p.z = z;
        pending_positions.push_back(p);
    endtask

    // positions in a cube around the earth, anywhere, near the centre, on the axis or on the x-z plane
    task automatic queue_random_position();
        int kind;
        kind = $urandom_range(0, 99);
        if (kind < 45)
            queue_position(span_coord(700000000), span_coord(700000000),
                           span_coord(700000000));
        else if (kind < 75)
            queue_position(31'($urandom), 31'($urandom), 31'($urandom));
        else if (kind < 85)
            queue_position(span_coord(5000000), span_coord(5000000), span_coord(5000000));
        else if (kind < 92)
            // on the polar axis
            queue_position('0, '0, 31'($urandom));
        else
            // on the x-z plane, either side
            queue_position(31'($urandom), '0, 31'($urandom));
    endtask

    task automatic wait_drained();
        while (pending_positions.size() != 0 || s_valid || expected_fixes.size() != 0)
            @(posedge aclk);
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatch_count++;
        $display("mismatch %s: got %0d expected %0d at cycle %0d",
                 what, got, want, cycle_count);
    endtask

    // ------------------------------------------------------------------
    // input driver: one word from the pending queue per handshake
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (pending_positions.size() == 0 ||
                (!calm && $urandom_range(0, 99) < 36)) begin
                s_valid <= 1'b0;
            end else begin
                ecef_pos_t p;
                p = pending_positions.pop_front();
                // this word is the next one accepted, so its fix is next in line
                expected_fixes.push_back(predict_geodetic(p));
                s_ecef_x <= p.x;
                s_ecef_y <= p.y;
                s_ecef_z <= p.z;
                s_valid  <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // result monitor: random stalls, each taken word checked field by field
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_fixes.size() == 0) begin
                    report_mismatch("unexpected word", 0, 0);
                end else begin
                    geo_fix_t f;
                    f = expected_fixes.pop_front();
                    if (m_latitude !== f.lat) report_mismatch("latitude", m_latitude, f.lat);
                    if (m_longitude !== f.lon)
                        report_mismatch("longitude", m_longitude, f.lon);
                    if (m_height !== f.hgt) report_mismatch("height", m_height, f.hgt);
                    if (m_on_axis !== f.axis) report_mismatch("on_axis", m_on_axis, f.axis);
                end
            end
            m_ready <= calm || ($urandom_range(0, 99) >= 36);
        end
    end

    // run watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("ecef_to_geodetic_tb NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // sequence: reset, directed positions, random positions, drain
    // ------------------------------------------------------------------
    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // polar axis: centre, north, south, both extremes
        queue_position('0, '0, '0);
        queue_position('0, '0, 31'sd635675231);
        queue_position('0, '0, -31'sd635675231);
        queue_position('0, '0, 31'sh3FFFFFFF);
        queue_position('0, '0, 31'sh40000000);
        // negative x with zero y: east half turn
        queue_position(-31'sd637813700, '0, '0);
        queue_position(-31'sd1, '0, 31'sd5);
        // equator and cardinal directions
        queue_position(31'sd637813700, '0, '0);
        queue_position('0, 31'sd637813700, '0);
        queue_position('0, -31'sd637813700, '0);
        // field extremes
        queue_position(31'sh3FFFFFFF, 31'sh3FFFFFFF, 31'sh3FFFFFFF);
        queue_position(31'sh40000000, 31'sh40000000, 31'sh40000000);
        queue_position(31'sh40000000, 31'sh3FFFFFFF, 31'sh40000000);
        queue_position(31'sh3FFFFFFF, 31'sh40000000, 31'sh3FFFFFFF);
        queue_position(31'sd1, '0, 31'sh40000000);
        queue_position('0, -31'sd1, 31'sh3FFFFFFF);
        // deep interior, near the centre
        queue_position(31'sd1, 31'sd1, 31'sd1);
        queue_position(-31'sd3, 31'sd2, -31'sd7);
        queue_position(31'sd1000000, -31'sd2000000, 31'sd3000000);
        // mid latitudes and high altitude
        queue_position(31'sd451000000, 31'sd451000000, 31'sd448000000);
        queue_position(-31'sd300000000, -31'sd400000000, -31'sd450000000);
        queue_position(31'sd1000, 31'sd0, 31'sd635675000);
        wait_drained();

        // first random batch with the gapless stretch in the middle
        for (int i = 0; i < 700; i++) begin
            if (i == 200) calm = 1'b1;
            if (i == 450) calm = 1'b0;
            queue_random_position();
            while (pending_positions.size() > 16) @(posedge aclk);
        end
        // sender holds until every fix is back
        wait_drained();

        for (int i = 0; i < 700; i++) begin
            queue_random_position();
            while (pending_positions.size() > 16) @(posedge aclk);
        end
        wait_drained();
        repeat (PIPE_LAT + 50) @(posedge aclk);

        if (mismatch_count == 0 && expected_fixes.size() == 0) begin
            $display("ecef_to_geodetic_tb OK");
        end else begin
            $display("ecef_to_geodetic_tb NOT OK");
        end
        $finish;
    end

endmodule
